// ----- hw/rtl/pdts_pkg.sv -----
// Shared types and codes of the priority-decay thread scheduler.
package pdts_pkg;

  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_ADD    = 3'd1;
  localparam logic [2:0] FUNC_REMOVE = 3'd2;
  localparam logic [2:0] FUNC_PAUSE  = 3'd3;
  localparam logic [2:0] FUNC_WAKE   = 3'd4;
  localparam logic [2:0] FUNC_BLOCK  = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_STATE = 2'd1;
  localparam logic [1:0] ST_SHORT     = 2'd2;
  localparam logic [1:0] ST_BUSY      = 2'd3;

  localparam logic [9:0] MS_PER_TICK_RESET = 10'd10;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  thread_id;
    logic [4:0]  base_priority;
    logic [15:0] duration_ms;
  } in_t;

  typedef struct packed {
    logic [3:0]  selected_thread;
    logic        selected_valid;
    logic [4:0]  runnable_count;
    logic [4:0]  total_count;
    logic [31:0] tick_count;
    logic [1:0]  status;
  } out_t;

endpackage

// ----- hw/rtl/pdts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module pdts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/priority_decay_thread_scheduler.sv -----
// Top level of the priority-decay thread scheduler (multilevel feedback queue).
//
// Usage:
//   in_valid/in_stall carries one request transaction (in_data: func, thread_id,
//   base_priority, duration_ms). out_valid/out_stall carries one result
//   transaction per request: head of the highest non-empty level, counts,
//   tick count and a status code. cfg_wr_en/cfg_wr_data write ms_per_tick;
//   write it only while the block is idle.
// Request handling (one request at a time, set by the single-port
//   state memories and the list walk through the link memory):
//   - add, wake: enqueue; block, remove of a runnable thread: unlink by list walk.
//   - timed pause: the bit-serial divider runs first, then the unlink walk.
//   - tick: scan every slot, count down each timed wait and requeue each
//     expired one at its base level, then dequeue the selected head, decay
//     it and requeue it.
// Reset (rst_n low, synchronous): all slots absent, all levels empty, counters
//   zero, ms_per_tick back to 10. No clearing pass is needed.
// Stall: a result holds in the output register while out_stall is high; the
//   next request may be accepted meanwhile and finishes its work, then waits
//   for the output register before returning to idle.
module priority_decay_thread_scheduler #(
  parameter int NUM_LEVELS  = 32,
  parameter int NUM_THREADS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pdts_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pdts_pkg::out_t out_data,
  input  logic           cfg_wr_en,
  input  logic [9:0]     cfg_wr_data
);
  import pdts_pkg::*;

  localparam int TW = $clog2(NUM_THREADS);
  localparam int LW = $clog2(NUM_LEVELS);
  localparam int CW = $clog2(NUM_THREADS + 1);

  typedef enum logic [1:0] {
    MODE_ABSENT  = 2'd0,
    MODE_RUN     = 2'd1,
    MODE_BLOCKED = 2'd2,
    MODE_TIMED   = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_DISPATCH, S_TRD,
    S_ENQ0, S_ENQ1, S_ENQ2,
    S_DEQ0, S_DEQ1, S_DEQ2,
    S_SCAN, S_SCAN_W, S_SCAN_N,
    S_SEL, S_SEL_H, S_SEL_T, S_SEL_E,
    S_FIN, S_FIN_W
  } state_t;

  typedef struct packed {
    logic [LW-1:0] base;
    logic [LW-1:0] cur;
    logic [15:0]   wait_left;
  } thr_word_t;

  typedef struct packed {
    logic [TW-1:0] head;
    logic [TW-1:0] tail;
  } lvl_word_t;

  function automatic logic [LW-1:0] top_level(input logic [NUM_LEVELS-1:0] v);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (v[i]) r = LW'(i);
    end
    return r;
  endfunction

  // Registers
  state_t          state_r, state_nxt, ret_r, ret_nxt;
  logic [9:0]      ms_r;
  logic [2:0]      func_r, func_nxt;
  logic [TW-1:0]   tid_r, tid_nxt;
  logic            idok_r, idok_nxt;
  logic [LW-1:0]   bp_r, bp_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [15:0]     quo_r, quo_nxt;
  logic [9:0]      rem_r, rem_nxt;
  logic [3:0]      dcnt_r, dcnt_nxt;
  mode_t           mode_r [NUM_THREADS];
  mode_t           mode_nxt [NUM_THREADS];
  logic [NUM_LEVELS-1:0] occ_r, occ_nxt;
  logic [CW-1:0]   rcnt_r, rcnt_nxt, tot_r, tot_nxt;
  logic [31:0]     tick_r, tick_nxt;
  logic [TW-1:0]   sub_t_r, sub_t_nxt;
  logic [LW-1:0]   sub_lv_r, sub_lv_nxt;
  logic [TW-1:0]   lhead_r, lhead_nxt, ltail_r, ltail_nxt;
  logic [TW-1:0]   cur_r, cur_nxt, prev_r, prev_nxt, n_r, n_nxt;
  logic            hprev_r, hprev_nxt;
  logic [TW-1:0]   idx_r, idx_nxt;
  thr_word_t       thq_r, thq_nxt;
  out_t            out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Memory ports
  logic            thr_we, thr_re, lnk_we, lnk_re, lvl_we, lvl_re;
  logic [TW-1:0]   thr_wa, thr_ra, lnk_wa, lnk_ra, lnk_wd, lnk_rd;
  logic [LW-1:0]   lvl_wa, lvl_ra;
  thr_word_t       thr_wd, thr_rd;
  lvl_word_t       lvl_wd, lvl_rd;

  pdts_ram #(.WIDTH($bits(thr_word_t)), .DEPTH(NUM_THREADS)) u_thr_ram (
    .clk(clk), .we(thr_we), .waddr(thr_wa), .wdata(thr_wd),
    .re(thr_re), .raddr(thr_ra), .rdata(thr_rd)
  );

  pdts_ram #(.WIDTH(TW), .DEPTH(NUM_THREADS)) u_lnk_ram (
    .clk(clk), .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd),
    .re(lnk_re), .raddr(lnk_ra), .rdata(lnk_rd)
  );

  pdts_ram #(.WIDTH($bits(lvl_word_t)), .DEPTH(NUM_LEVELS)) u_lvl_ram (
    .clk(clk), .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd),
    .re(lvl_re), .raddr(lvl_ra), .rdata(lvl_rd)
  );

  logic          in_acc;
  logic [9:0]    divisor;
  logic [10:0]   trial;
  logic [LW-1:0] hi_lv;
  logic          any_occ;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign divisor   = (ms_r == '0) ? 10'd1 : ms_r;
  assign trial     = {rem_r, quo_r[15]};
  assign hi_lv     = top_level(occ_r);
  assign any_occ   = (occ_r != '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    func_nxt   = func_r;
    tid_nxt    = tid_r;
    idok_nxt   = idok_r;
    bp_nxt     = bp_r;
    status_nxt = status_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dcnt_nxt   = dcnt_r;
    mode_nxt   = mode_r;
    occ_nxt    = occ_r;
    rcnt_nxt   = rcnt_r;
    tot_nxt    = tot_r;
    tick_nxt   = tick_r;
    sub_t_nxt  = sub_t_r;
    sub_lv_nxt = sub_lv_r;
    lhead_nxt  = lhead_r;
    ltail_nxt  = ltail_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    n_nxt      = n_r;
    hprev_nxt  = hprev_r;
    idx_nxt    = idx_r;
    thq_nxt    = thq_r;
    out_nxt    = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    thr_we = 1'b0; thr_wa = '0; thr_wd = '0; thr_re = 1'b0; thr_ra = '0;
    lnk_we = 1'b0; lnk_wa = '0; lnk_wd = '0; lnk_re = 1'b0; lnk_ra = '0;
    lvl_we = 1'b0; lvl_wa = '0; lvl_wd = '0; lvl_re = 1'b0; lvl_ra = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // Capture the request transaction.
          func_nxt   = in_data.func;
          tid_nxt    = TW'(in_data.thread_id);
          idok_nxt   = int'(in_data.thread_id) < NUM_THREADS;
          bp_nxt     = (int'(in_data.base_priority) > NUM_LEVELS - 1) ?
                       LW'(NUM_LEVELS - 1) : LW'(in_data.base_priority);
          status_nxt = ST_OK;
          quo_nxt    = in_data.duration_ms;
          rem_nxt    = '0;
          dcnt_nxt   = '0;
          state_nxt  = (in_data.func == FUNC_PAUSE) ? S_DIV : S_DISPATCH;
        end
      end

      S_DIV: begin
        // One quotient bit per cycle.
        if (trial >= {1'b0, divisor}) begin
          rem_nxt = 10'(trial - {1'b0, divisor});
          quo_nxt = {quo_r[14:0], 1'b1};
        end else begin
          rem_nxt = trial[9:0];
          quo_nxt = {quo_r[14:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'd15) state_nxt = S_DISPATCH;
      end

      S_DISPATCH: begin
        state_nxt = S_FIN;
        if (func_r == FUNC_TICK) begin
          tick_nxt  = tick_r + 32'd1;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end else if (func_r <= FUNC_BLOCK && !idok_r) begin
          status_nxt = ST_BAD_STATE;
        end else if (func_r == FUNC_ADD) begin
          if (mode_r[tid_r] != MODE_ABSENT) begin
            status_nxt = ST_BUSY;
          end else begin
            thr_we = 1'b1; thr_wa = tid_r;
            thr_wd = '{base: bp_r, cur: bp_r, wait_left: 16'd0};
            mode_nxt[tid_r] = MODE_RUN;
            tot_nxt    = tot_r + CW'(1);
            sub_t_nxt  = tid_r;
            sub_lv_nxt = bp_r;
            ret_nxt    = S_FIN;
            state_nxt  = S_ENQ0;
          end
        end else if (func_r == FUNC_REMOVE) begin
          if (mode_r[tid_r] == MODE_ABSENT) status_nxt = ST_BAD_STATE;
          else begin
            thr_re = 1'b1; thr_ra = tid_r; state_nxt = S_TRD;
          end
        end else if (func_r == FUNC_PAUSE) begin
          // Short duration is checked before the thread's mode.
          if (quo_r == '0) status_nxt = ST_SHORT;
          else if (mode_r[tid_r] != MODE_RUN) status_nxt = ST_BAD_STATE;
          else begin
            thr_re = 1'b1; thr_ra = tid_r; state_nxt = S_TRD;
          end
        end else if (func_r == FUNC_WAKE) begin
          if (mode_r[tid_r] != MODE_BLOCKED && mode_r[tid_r] != MODE_TIMED)
            status_nxt = ST_BAD_STATE;
          else begin
            thr_re = 1'b1; thr_ra = tid_r; state_nxt = S_TRD;
          end
        end else if (func_r == FUNC_BLOCK) begin
          if (mode_r[tid_r] != MODE_RUN) status_nxt = ST_BAD_STATE;
          else begin
            thr_re = 1'b1; thr_ra = tid_r; state_nxt = S_TRD;
          end
        end
      end

      S_TRD: begin
        // Slot word is here; finish the request.
        sub_t_nxt  = tid_r;
        sub_lv_nxt = thr_rd.cur;
        ret_nxt    = S_FIN;
        state_nxt  = S_FIN;
        if (func_r == FUNC_REMOVE) begin
          mode_nxt[tid_r] = MODE_ABSENT;
          tot_nxt = tot_r - CW'(1);
          if (mode_r[tid_r] == MODE_RUN) state_nxt = S_DEQ0;
        end else if (func_r == FUNC_PAUSE) begin
          thr_we = 1'b1; thr_wa = tid_r;
          thr_wd = '{base: thr_rd.base, cur: thr_rd.cur, wait_left: quo_r};
          mode_nxt[tid_r] = MODE_TIMED;
          state_nxt = S_DEQ0;
        end else if (func_r == FUNC_WAKE) begin
          thr_we = 1'b1; thr_wa = tid_r;
          thr_wd = '{base: thr_rd.base, cur: thr_rd.base, wait_left: 16'd0};
          mode_nxt[tid_r] = MODE_RUN;
          sub_lv_nxt = thr_rd.base;
          state_nxt  = S_ENQ0;
        end else begin
          mode_nxt[tid_r] = MODE_BLOCKED;
          state_nxt = S_DEQ0;
        end
      end

      S_ENQ0: begin
        lvl_re = 1'b1; lvl_ra = sub_lv_r;
        state_nxt = S_ENQ1;
      end

      S_ENQ1: begin
        lhead_nxt = lvl_rd.head;
        if (occ_r[sub_lv_r]) begin
          lnk_we = 1'b1; lnk_wa = lvl_rd.tail; lnk_wd = sub_t_r;
        end
        state_nxt = S_ENQ2;
      end

      S_ENQ2: begin
        lnk_we = 1'b1; lnk_wa = sub_t_r; lnk_wd = sub_t_r;
        lvl_we = 1'b1; lvl_wa = sub_lv_r;
        lvl_wd = '{head: occ_r[sub_lv_r] ? lhead_r : sub_t_r, tail: sub_t_r};
        occ_nxt[sub_lv_r] = 1'b1;
        rcnt_nxt  = rcnt_r + CW'(1);
        state_nxt = ret_r;
      end

      S_DEQ0: begin
        if (!occ_r[sub_lv_r]) state_nxt = ret_r;
        else begin
          lvl_re = 1'b1; lvl_ra = sub_lv_r; state_nxt = S_DEQ1;
        end
      end

      S_DEQ1: begin
        lhead_nxt = lvl_rd.head;
        ltail_nxt = lvl_rd.tail;
        cur_nxt   = lvl_rd.head;
        hprev_nxt = 1'b0;
        n_nxt     = '0;
        lnk_re = 1'b1; lnk_ra = lvl_rd.head;
        state_nxt = S_DEQ2;
      end

      S_DEQ2: begin
        // Walk the list one link per cycle; lnk_rd is the link of cur.
        if (cur_r == sub_t_r) begin
          if (!hprev_r) begin
            if (cur_r == ltail_r) occ_nxt[sub_lv_r] = 1'b0;
            else begin
              lvl_we = 1'b1; lvl_wa = sub_lv_r;
              lvl_wd = '{head: lnk_rd, tail: ltail_r};
            end
          end else begin
            lnk_we = 1'b1; lnk_wa = prev_r; lnk_wd = lnk_rd;
            if (cur_r == ltail_r) begin
              lvl_we = 1'b1; lvl_wa = sub_lv_r;
              lvl_wd = '{head: lhead_r, tail: prev_r};
            end
          end
          rcnt_nxt  = rcnt_r - CW'(1);
          state_nxt = ret_r;
        end else if (cur_r == ltail_r || n_r == TW'(NUM_THREADS - 1)) begin
          state_nxt = ret_r;
        end else begin
          prev_nxt  = cur_r;
          hprev_nxt = 1'b1;
          cur_nxt   = lnk_rd;
          n_nxt     = n_r + TW'(1);
          lnk_re = 1'b1; lnk_ra = lnk_rd;
        end
      end

      S_SCAN: begin
        if (mode_r[idx_r] == MODE_TIMED) begin
          thr_re = 1'b1; thr_ra = idx_r; state_nxt = S_SCAN_W;
        end else begin
          state_nxt = S_SCAN_N;
        end
      end

      S_SCAN_W: begin
        thr_we = 1'b1; thr_wa = idx_r;
        if (thr_rd.wait_left <= 16'd1) begin
          // Wait ran out: rejoin at the base level.
          thr_wd = '{base: thr_rd.base, cur: thr_rd.base, wait_left: 16'd0};
          mode_nxt[idx_r] = MODE_RUN;
          sub_t_nxt  = idx_r;
          sub_lv_nxt = thr_rd.base;
          ret_nxt    = S_SCAN_N;
          state_nxt  = S_ENQ0;
        end else begin
          thr_wd = '{base: thr_rd.base, cur: thr_rd.cur,
                     wait_left: thr_rd.wait_left - 16'd1};
          state_nxt = S_SCAN_N;
        end
      end

      S_SCAN_N: begin
        if (idx_r == TW'(NUM_THREADS - 1)) state_nxt = S_SEL;
        else begin
          idx_nxt = idx_r + TW'(1); state_nxt = S_SCAN;
        end
      end

      S_SEL: begin
        if (any_occ) begin
          lvl_re = 1'b1; lvl_ra = hi_lv; state_nxt = S_SEL_H;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_SEL_H: begin
        sub_t_nxt = lvl_rd.head;
        thr_re = 1'b1; thr_ra = lvl_rd.head;
        state_nxt = S_SEL_T;
      end

      S_SEL_T: begin
        thq_nxt    = thr_rd;
        sub_lv_nxt = thr_rd.cur;
        ret_nxt    = S_SEL_E;
        state_nxt  = S_DEQ0;
      end

      S_SEL_E: begin
        // Decay one level, or reload from base at level zero, then requeue.
        thr_we = 1'b1; thr_wa = sub_t_r;
        thr_wd = thq_r;
        thr_wd.cur = (thq_r.cur != '0) ? thq_r.cur - LW'(1) : thq_r.base;
        sub_lv_nxt = thr_wd.cur;
        ret_nxt    = S_FIN;
        state_nxt  = S_ENQ0;
      end

      S_FIN: begin
        if (any_occ) begin
          lvl_re = 1'b1; lvl_ra = hi_lv;
        end
        state_nxt = S_FIN_W;
      end

      S_FIN_W: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_nxt.selected_thread = any_occ ? 4'(lvl_rd.head) : 4'd0;
          out_nxt.selected_valid  = any_occ;
          out_nxt.runnable_count  = 5'(rcnt_r);
          out_nxt.total_count     = 5'(tot_r);
          out_nxt.tick_count      = tick_r;
          out_nxt.status          = status_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_FIN;
      ms_r        <= MS_PER_TICK_RESET;
      occ_r       <= '0;
      rcnt_r      <= '0;
      tot_r       <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_THREADS; i++) mode_r[i] <= MODE_ABSENT;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      if (cfg_wr_en) ms_r <= cfg_wr_data;
      occ_r       <= occ_nxt;
      rcnt_r      <= rcnt_nxt;
      tot_r       <= tot_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
    end
    func_r   <= func_nxt;
    tid_r    <= tid_nxt;
    idok_r   <= idok_nxt;
    bp_r     <= bp_nxt;
    status_r <= status_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dcnt_r   <= dcnt_nxt;
    sub_t_r  <= sub_t_nxt;
    sub_lv_r <= sub_lv_nxt;
    lhead_r  <= lhead_nxt;
    ltail_r  <= ltail_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    n_r      <= n_nxt;
    hprev_r  <= hprev_nxt;
    idx_r    <= idx_nxt;
    thq_r    <= thq_nxt;
    out_r    <= out_nxt;
  end

  // Between requests, runnable threads are a subset of present threads.
  a_run_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (rcnt_r <= tot_r))
    else $error("runnable count exceeds total count");

  // Between requests, the occupancy mask and runnable count agree.
  a_occ_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((occ_r == '0) == (rcnt_r == '0)))
    else $error("level occupancy disagrees with runnable count");

  // A reported selection goes with a non-empty run queue.
  a_sel_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.selected_valid == (out_r.runnable_count != 5'd0)))
    else $error("selected_valid inconsistent with runnable_count");

endmodule

// ----- bench/tb_priority_decay_thread_scheduler.sv -----
// Self-checking testbench for the priority-decay thread scheduler.
module tb_priority_decay_thread_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import pdts_pkg::*;

  localparam int LEVELS   = 32;
  localparam int THREADS  = 16;
  localparam int WATCHDOG = 20000;

  typedef enum logic [1:0] {
    SLOT_ABSENT  = 2'd0,
    SLOT_RUN     = 2'd1,
    SLOT_BLOCKED = 2'd2,
    SLOT_TIMED   = 2'd3
  } slot_mode_e;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_wr_en;
  logic [9:0] cfg_wr_data;

  priority_decay_thread_scheduler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Scheduler shadow state.
  logic [9:0]  sh_ms_per_tick;
  logic [4:0]  sh_base [THREADS];
  logic [4:0]  sh_cur [THREADS];
  slot_mode_e  sh_mode [THREADS];
  logic [15:0] sh_wait [THREADS];
  logic [3:0]  sh_link [THREADS];
  logic [3:0]  sh_head [LEVELS];
  logic [3:0]  sh_tail [LEVELS];
  logic [LEVELS-1:0] sh_occupied;
  logic [4:0]  sh_runnable;
  logic [31:0] sh_ticks;

  out_t pending_results[$];
  int   mismatch_count;
  int   result_count;
  int   idle_cycles;
  int   send_idle_pct;
  int   recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void shadow_reset();
    sh_ms_per_tick = MS_PER_TICK_RESET;
    for (int i = 0; i < THREADS; i++) begin
      sh_base[i] = '0;
      sh_cur[i]  = '0;
      sh_mode[i] = SLOT_ABSENT;
      sh_wait[i] = '0;
      sh_link[i] = '0;
    end
    for (int l = 0; l < LEVELS; l++) begin
      sh_head[l] = '0;
      sh_tail[l] = '0;
    end
    sh_occupied = '0;
    sh_runnable = '0;
    sh_ticks    = '0;
  endfunction

  // Append a thread at the tail of its current level.
  function automatic void join_level(int t);
    int lv;
    lv = sh_cur[t];
    sh_link[t] = t[3:0];
    if (sh_occupied[lv]) sh_link[sh_tail[lv]] = t[3:0];
    else sh_head[lv] = t[3:0];
    sh_tail[lv] = t[3:0];
    sh_occupied[lv] = 1'b1;
    sh_runnable++;
  endfunction

  // Unlink a thread from its current level, walking from the head.
  function automatic void leave_level(int t);
    int lv;
    int prev;
    int cur;
    bit have_prev;
    lv = sh_cur[t];
    have_prev = 0;
    prev = 0;
    if (!sh_occupied[lv]) return;
    cur = sh_head[lv];
    for (int n = 0; n < THREADS; n++) begin
      if (cur == t) begin
        if (!have_prev) begin
          if (cur == sh_tail[lv]) sh_occupied[lv] = 1'b0;
          else sh_head[lv] = sh_link[cur];
        end else begin
          sh_link[prev] = sh_link[cur];
          if (cur == sh_tail[lv]) sh_tail[lv] = prev[3:0];
        end
        sh_runnable--;
        return;
      end
      if (cur == sh_tail[lv]) return;
      prev = cur;
      have_prev = 1;
      cur = sh_link[cur];
    end
  endfunction

  function automatic int top_level();
    for (int l = LEVELS - 1; l >= 0; l--)
      if (sh_occupied[l]) return l;
    return -1;
  endfunction

  function automatic void run_tick();
    int h;
    int t;
    sh_ticks++;
    for (int i = 0; i < THREADS; i++) begin
      if (sh_mode[i] != SLOT_TIMED) continue;
      if (sh_wait[i] <= 1) begin
        sh_wait[i] = '0;
        sh_mode[i] = SLOT_RUN;
        sh_cur[i] = sh_base[i];
        join_level(i);
      end else begin
        sh_wait[i]--;
      end
    end
    h = top_level();
    if (h >= 0) begin
      t = sh_head[h];
      leave_level(t);
      if (sh_cur[t] > 0) sh_cur[t]--;
      else sh_cur[t] = sh_base[t];
      join_level(t);
    end
  endfunction

  // Apply one request to the shadow state and return the result it yields.
  function automatic out_t schedule_request(in_t req);
    out_t res;
    int t;
    int h;
    int total;
    int ticks;
    logic [1:0] st;
    t = req.thread_id;
    st = ST_OK;
    case (req.func)
      FUNC_TICK: run_tick();
      FUNC_ADD: begin
        if (sh_mode[t] != SLOT_ABSENT) st = ST_BUSY;
        else begin
          sh_base[t] = req.base_priority;
          sh_cur[t]  = req.base_priority;
          sh_wait[t] = '0;
          sh_mode[t] = SLOT_RUN;
          join_level(t);
        end
      end
      FUNC_REMOVE: begin
        if (sh_mode[t] == SLOT_ABSENT) st = ST_BAD_STATE;
        else begin
          if (sh_mode[t] == SLOT_RUN) leave_level(t);
          sh_mode[t] = SLOT_ABSENT;
          sh_wait[t] = '0;
        end
      end
      FUNC_PAUSE: begin
        ticks = req.duration_ms / ((sh_ms_per_tick == 0) ? 1 : sh_ms_per_tick);
        if (ticks == 0) st = ST_SHORT;
        else if (sh_mode[t] != SLOT_RUN) st = ST_BAD_STATE;
        else begin
          leave_level(t);
          sh_mode[t] = SLOT_TIMED;
          sh_wait[t] = ticks[15:0];
        end
      end
      FUNC_WAKE: begin
        if (sh_mode[t] != SLOT_BLOCKED && sh_mode[t] != SLOT_TIMED) st = ST_BAD_STATE;
        else begin
          sh_wait[t] = '0;
          sh_mode[t] = SLOT_RUN;
          sh_cur[t] = sh_base[t];
          join_level(t);
        end
      end
      FUNC_BLOCK: begin
        if (sh_mode[t] != SLOT_RUN) st = ST_BAD_STATE;
        else begin
          leave_level(t);
          sh_mode[t] = SLOT_BLOCKED;
        end
      end
      default: ;
    endcase
    total = 0;
    for (int i = 0; i < THREADS; i++)
      if (sh_mode[i] != SLOT_ABSENT) total++;
    h = top_level();
    res.selected_thread = (h >= 0) ? sh_head[h] : 4'd0;
    res.selected_valid  = (h >= 0);
    res.runnable_count  = sh_runnable;
    res.total_count     = total[4:0];
    res.tick_count      = sh_ticks;
    res.status          = st;
    return res;
  endfunction

  // Drive one request transaction and queue its expected result on acceptance.
  // Valid stays high after acceptance; idle gaps and drain waits drop it.
  task automatic send_request(logic [2:0] func, int tid, int prio, int dur);
    in_t req;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    req.func = func;
    req.thread_id = tid[3:0];
    req.base_priority = prio[4:0];
    req.duration_ms = dur[15:0];
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(schedule_request(req));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_ms_per_tick(logic [9:0] value);
    wait_drained();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sh_ms_per_tick = value;
  endtask

  // Pick a random request with random thread, priority and duration; a few use undefined codes.
  task automatic send_random_request();
    int f;
    int r;
    r = $urandom_range(99);
    if (r < 30) f = FUNC_TICK;
    else if (r < 50) f = FUNC_ADD;
    else if (r < 60) f = FUNC_REMOVE;
    else if (r < 72) f = FUNC_PAUSE;
    else if (r < 84) f = FUNC_WAKE;
    else if (r < 96) f = FUNC_BLOCK;
    else f = $urandom_range(7, 6);
    send_request(f[2:0], $urandom_range(15), $urandom_range(31),
                 ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(200));
  endtask

  task automatic test_directed();
    // Fill extremes: lowest and highest level, then busy slot.
    send_request(FUNC_TICK, 0, 0, 0);
    send_request(FUNC_ADD, 0, 0, 0);
    send_request(FUNC_ADD, 15, 31, 16'hFFFF);
    send_request(FUNC_ADD, 15, 5, 0);
    send_request(FUNC_ADD, 7, 31, 0);
    send_request(FUNC_TICK, 0, 0, 0);
    send_request(FUNC_TICK, 0, 0, 0);
    // Pause too short is checked before the slot's mode.
    send_request(FUNC_PAUSE, 3, 0, 9);
    send_request(FUNC_PAUSE, 15, 0, 20);
    send_request(FUNC_PAUSE, 15, 0, 10);
    send_request(FUNC_PAUSE, 7, 0, 10);
    send_request(FUNC_TICK, 0, 0, 0);
    send_request(FUNC_BLOCK, 0, 0, 0);
    send_request(FUNC_BLOCK, 0, 0, 0);
    send_request(FUNC_WAKE, 0, 0, 0);
    send_request(FUNC_WAKE, 3, 0, 0);
    send_request(FUNC_BLOCK, 15, 0, 0);
    send_request(FUNC_REMOVE, 15, 0, 0);
    send_request(FUNC_REMOVE, 15, 0, 0);
    send_request(3'd6, 2, 0, 0);
    send_request(3'd7, 2, 0, 0);
    send_request(FUNC_REMOVE, 0, 0, 0);
    send_request(FUNC_PAUSE, 7, 0, 16'hFFFF);
    send_request(FUNC_WAKE, 7, 0, 0);
  endtask

  task automatic test_divider_extremes();
    write_ms_per_tick(10'd1);
    send_request(FUNC_ADD, 4, 3, 0);
    send_request(FUNC_PAUSE, 4, 0, 1);
    send_request(FUNC_TICK, 0, 0, 0);
    write_ms_per_tick(10'd1023);
    send_request(FUNC_PAUSE, 4, 0, 1022);
    send_request(FUNC_PAUSE, 4, 0, 16'hFFFF);
    write_ms_per_tick(10'd0);
    send_request(FUNC_PAUSE, 4, 0, 0);
    send_request(FUNC_WAKE, 4, 0, 0);
    write_ms_per_tick(10'd1000);
  endtask

  task automatic test_random_phase(int count, int idle_pct, int stall_pct, logic [9:0] mpt);
    write_ms_per_tick(mpt);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) send_random_request();
  endtask

  task automatic test_hold_until_drained();
    // Stop sending until every result is back, then resume.
    send_request(FUNC_ADD, 9, 12, 0);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    send_request(FUNC_TICK, 0, 0, 0);
  endtask

  // Receiver: random stall, compare each accepted result against the oldest.
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && (in_valid && !in_stall || out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      result_count <= result_count + 1;
      if (pending_results.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10) $display("unexpected result transaction %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    mismatch_count = 0;
    result_count = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shadow_reset();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_divider_extremes();
    test_random_phase(200, 0, 0, 10'd10);
    test_random_phase(200, 58, 0, 10'd1);
    test_hold_until_drained();
    test_random_phase(200, 0, 58, 10'd3);
    test_random_phase(200, 15, 15, 10'd1023);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    $display("Covered directed cases, divider extremes and random requests under idle/stall mixes;");
    $display("%0d results checked, %0d mismatches.", result_count, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Watchdog on cycles without any accepted transaction.
  initial begin
    wait (idle_cycles >= WATCHDOG);
    $display("Some tests failed");
    $finish;
  end
endmodule
